[sv/pufm_pkg.sv]
`timescale 1ns / 1ps
package pufm_pkg;

  localparam int TREE_LEVELS  = 10;
  localparam int MAX_ELEMENTS = 1024;

  localparam logic [1:0] KIND_LOAD  = 2'd0;
  localparam logic [1:0] KIND_JOIN  = 2'd1;
  localparam logic [1:0] KIND_QMIN  = 2'd2;
  localparam logic [1:0] KIND_SAME  = 2'd3;

  localparam logic [1:0] ST_OK        = 2'd0;
  localparam logic [1:0] ST_EXHAUSTED = 2'd1;
  localparam logic [1:0] ST_REJECTED  = 2'd2;

  typedef struct packed {
    logic [1:0]  kind;
    logic [15:0] version;
    logic [9:0]  first_element;
    logic [9:0]  second_element;
    logic [31:0] load_value;
  } in_item_t;

  typedef struct packed {
    logic [15:0] new_version;
    logic [31:0] min_key;
    logic        same_set;
    logic [1:0]  status;
  } out_item_t;

endpackage

[sv/pufm_pool.sv]
`timescale 1ns / 1ps
// Node pool: child pointers, leaf parent, rank and key. One access per cycle,
// registered read data. Contents are undefined until written; the owner
// writes the initial tree after reset.
module pufm_pool #(
  parameter int NODE_W = 16,
  parameter int ELEM_W = 10
) (
  input  logic              clk,
  input  logic              rd_en,
  input  logic [NODE_W-1:0] rd_addr,
  output logic [NODE_W-1:0] rd_left,
  output logic [NODE_W-1:0] rd_right,
  output logic [ELEM_W-1:0] rd_parent,
  output logic [3:0]        rd_rank,
  output logic [31:0]       rd_key,
  input  logic              wr_child,
  input  logic              wr_leaf,
  input  logic              wr_key_only,
  input  logic [NODE_W-1:0] wr_addr,
  input  logic [NODE_W-1:0] wr_left,
  input  logic [NODE_W-1:0] wr_right,
  input  logic [ELEM_W-1:0] wr_parent,
  input  logic [3:0]        wr_rank,
  input  logic [31:0]       wr_key
);
  localparam int DEPTH = 1 << NODE_W;

  logic [NODE_W-1:0] left_mem [DEPTH];
  logic [NODE_W-1:0] right_mem [DEPTH];
  logic [ELEM_W-1:0] parent_mem [DEPTH];
  logic [3:0]        rank_mem [DEPTH];
  logic [31:0]       key_mem [DEPTH];

  logic [NODE_W-1:0] l_q_r, r_q_r;
  logic [ELEM_W-1:0] p_q_r;
  logic [3:0]        k4_r;
  logic [31:0]       key_q_r;

  always_ff @(posedge clk) begin
    if (wr_child) begin
      left_mem[wr_addr]  <= wr_left;
      right_mem[wr_addr] <= wr_right;
    end
    if (wr_leaf) begin
      parent_mem[wr_addr] <= wr_parent;
      rank_mem[wr_addr]   <= wr_rank;
    end
    if (wr_leaf || wr_key_only) key_mem[wr_addr] <= wr_key;
    if (rd_en) begin
      l_q_r   <= left_mem[rd_addr];
      r_q_r   <= right_mem[rd_addr];
      p_q_r   <= parent_mem[rd_addr];
      k4_r    <= rank_mem[rd_addr];
      key_q_r <= key_mem[rd_addr];
    end
  end

  assign rd_left   = l_q_r;
  assign rd_right  = r_q_r;
  assign rd_parent = p_q_r;
  assign rd_rank   = k4_r;
  assign rd_key    = key_q_r;
endmodule

[sv/persistent_union_find_min_unit.sv]
`timescale 1ns / 1ps
// Load writes the leaf key unless a join has been taken. Query min walks from the
// version root down to the element's leaf and repeats for each parent hop;
// same-set adds a second find; a join adds two path copies, then a merge of rank and key.
// One item at a time through a single pool port; a new beat is taken once
// the result beat has gone. Reset (synchronous, rst_n low) is followed by
// writing the initial tree, with the input stalled.
module persistent_union_find_min_unit (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  output logic                 in_stall,
  input  pufm_pkg::in_item_t   in_data,
  output logic                 out_valid,
  input  logic                 out_stall,
  output pufm_pkg::out_item_t  out_data
);
  import pufm_pkg::*;

  localparam int NW = 16;
  localparam int EW = 10;
  localparam int LW = $clog2(TREE_LEVELS + 1);
  localparam logic [NW:0] INIT_FREE = (NW+1)'(2 << TREE_LEVELS);
  localparam logic [NW:0] POOL = (NW+1)'(1 << NW);
  localparam logic [NW:0] NEED = (NW+1)'(2 * (TREE_LEVELS + 1));
  localparam logic [EW-1:0] EMASK = EW'((1 << TREE_LEVELS) - 1);
  localparam logic [EW:0] HOPS = (EW+1)'(1 << TREE_LEVELS);

  typedef enum logic [4:0] {
    S_INIT, S_IDLE, S_WALK_RD, S_WALK_WT, S_LEAF_WT, S_HOP,
    S_CMP, S_CP_RD, S_CP_WT, S_CP_LEAF_RD, S_CP_LEAF_WT,
    S_RANK_RD, S_RANK_WT, S_FIX
  } state_t;

  state_t state_r;
  in_item_t it_r;
  logic [NW:0] free_r;
  logic joined_r;
  logic [NW-1:0] node_r;
  logic [LW-1:0] lvl_r;
  logic [EW-1:0] e_r;
  logic [EW:0] hops_r;
  logic which_r;              // 0: find on x, 1: find on y
  logic [EW-1:0] px_r;
  logic [3:0] rkx_r;
  logic copy2_r;              // second path copy
  logic [EW-1:0] ce_r, cp_r;
  logic [NW-1:0] nx_r, ny_r, root_r;
  logic [3:0] rk_nx_r;
  logic [31:0] key_nx_r;
  out_item_t res_r;
  logic ov_r;

  logic rd_en;
  logic [NW-1:0] rd_addr;
  logic [NW-1:0] rd_left, rd_right;
  logic [EW-1:0] rd_parent;
  logic [3:0] rd_rank;
  logic [31:0] rd_key;
  logic wr_child, wr_leaf, wr_key_only;
  logic [NW-1:0] wr_addr, wr_left, wr_right;
  logic [EW-1:0] wr_parent;
  logic [3:0] wr_rank;
  logic [31:0] wr_key;

  pufm_pool #(.NODE_W(NW), .ELEM_W(EW)) u_pool (
    .clk, .rd_en, .rd_addr, .rd_left, .rd_right, .rd_parent,
    .rd_rank, .rd_key, .wr_child, .wr_leaf, .wr_key_only, .wr_addr,
    .wr_left, .wr_right, .wr_parent, .wr_rank, .wr_key
  );

  wire take = in_valid && !in_stall;
  assign in_stall = (state_r != S_IDLE) || ov_r;
  assign out_valid = ov_r;
  assign out_data = res_r;

  wire bit_e = e_r[lvl_r - LW'(1)];
  wire bit_c = ce_r[lvl_r - LW'(1)];
  wire [NW-1:0] cur = free_r[NW-1:0];
  wire inner = (node_r < NW'(1 << TREE_LEVELS));

  always_comb begin
    rd_en = 1'b0;
    rd_addr = node_r;
    wr_child = 1'b0;
    wr_leaf = 1'b0;
    wr_key_only = 1'b0;
    wr_addr = cur;
    wr_left = rd_left;
    wr_right = rd_right;
    wr_parent = cp_r;
    wr_rank = rd_rank;
    wr_key = rd_key;
    case (state_r)
      S_INIT: begin
        // initial tree: node i has children 2i, 2i+1; leaf 2^L+e holds e
        wr_child = 1'b1;
        wr_leaf = 1'b1;
        wr_addr = node_r;
        wr_left = inner ? {node_r[NW-2:0], 1'b0} : '0;
        wr_right = inner ? {node_r[NW-2:0], 1'b1} : '0;
        wr_parent = inner ? '0 : (EW'(node_r) & EMASK);
        wr_rank = 4'd0;
        wr_key = 32'd0;
      end
      S_IDLE: begin
        wr_key_only = take && in_data.kind == KIND_LOAD && !joined_r &&
                      ({6'd0, in_data.first_element} < 16'(MAX_ELEMENTS));
        wr_addr = NW'((1 << TREE_LEVELS)) + NW'(in_data.first_element & EMASK);
        wr_key = in_data.load_value;
      end
      S_WALK_RD, S_LEAF_WT, S_CP_RD, S_CP_LEAF_RD: rd_en = 1'b1;
      S_RANK_RD: begin
        rd_en = 1'b1;
        rd_addr = ny_r;
      end
      S_CP_WT: begin
        wr_child = 1'b1;
        if (bit_c) wr_right = cur + NW'(1);
        else wr_left = cur + NW'(1);
      end
      S_CP_LEAF_WT: wr_leaf = 1'b1;
      S_FIX: begin
        wr_key_only = 1'b1;
        wr_addr = nx_r;
        wr_key = (rd_key < key_nx_r) ? rd_key : key_nx_r;
        wr_leaf = 1'b1;
        wr_parent = px_r;
        wr_rank = (rk_nx_r == rd_rank && rk_nx_r != 4'd15) ? rk_nx_r + 4'd1 : rk_nx_r;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_INIT;
      node_r <= '0;
      ov_r <= 1'b0;
      free_r <= INIT_FREE;
      joined_r <= 1'b0;
    end else begin
      if (ov_r && !out_stall) ov_r <= 1'b0;
      case (state_r)
        S_INIT: begin
          node_r <= node_r + NW'(1);
          if (node_r == INIT_FREE[NW-1:0] - NW'(1)) state_r <= S_IDLE;
        end
        S_IDLE: if (take) begin
          it_r <= in_data;
          res_r <= '{new_version: in_data.version, min_key: 32'd0, same_set: 1'b0,
                     status: (in_data.kind == KIND_LOAD && joined_r) ? ST_REJECTED : ST_OK};
          if (in_data.kind == KIND_LOAD) begin
            ov_r <= 1'b1;
          end else begin
            if (in_data.kind == KIND_JOIN) joined_r <= 1'b1;
            e_r <= in_data.first_element & EMASK;
            node_r <= in_data.version;
            lvl_r <= LW'(TREE_LEVELS);
            hops_r <= '0;
            which_r <= 1'b0;
            state_r <= S_WALK_RD;
          end
        end
        S_WALK_RD: state_r <= S_WALK_WT;
        S_WALK_WT: begin
          node_r <= bit_e ? rd_right : rd_left;
          lvl_r <= lvl_r - LW'(1);
          state_r <= (lvl_r == LW'(1)) ? S_LEAF_WT : S_WALK_RD;
        end
        S_LEAF_WT: state_r <= S_HOP;  // leaf read issued here
        S_HOP: state_r <= S_CMP;
        S_CMP: begin
          if (rd_parent != e_r && hops_r < HOPS) begin
            e_r <= rd_parent & EMASK;
            node_r <= it_r.version;
            lvl_r <= LW'(TREE_LEVELS);
            hops_r <= hops_r + (EW+1)'(1);
            state_r <= S_WALK_RD;
          end else if (!which_r) begin
            px_r <= rd_parent;
            rkx_r <= rd_rank;
            if (it_r.kind == KIND_QMIN) begin
              res_r.min_key <= rd_key;
              ov_r <= 1'b1;
              state_r <= S_IDLE;
            end else begin
              which_r <= 1'b1;
              e_r <= it_r.second_element & EMASK;
              node_r <= it_r.version;
              lvl_r <= LW'(TREE_LEVELS);
              hops_r <= '0;
              state_r <= S_WALK_RD;
            end
          end else begin
            if (it_r.kind == KIND_SAME) begin
              res_r.same_set <= (rd_parent == px_r);
              ov_r <= 1'b1;
              state_r <= S_IDLE;
            end else if (rd_parent == px_r) begin
              ov_r <= 1'b1;
              state_r <= S_IDLE;
            end else if (free_r + NEED > POOL) begin
              res_r.status <= ST_EXHAUSTED;
              ov_r <= 1'b1;
              state_r <= S_IDLE;
            end else begin
              // winner x keeps higher rank; swap when rank x < rank y
              if (rkx_r < rd_rank) begin
                px_r <= rd_parent;
                ce_r <= px_r;
                cp_r <= rd_parent;
              end else begin
                ce_r <= rd_parent;
                cp_r <= px_r;
              end
              copy2_r <= 1'b0;
              node_r <= it_r.version;
              lvl_r <= LW'(TREE_LEVELS);
              state_r <= S_CP_RD;
            end
          end
        end
        S_CP_RD: state_r <= S_CP_WT;
        S_CP_WT: begin
          node_r <= bit_c ? rd_right : rd_left;
          if (lvl_r == LW'(TREE_LEVELS)) root_r <= cur;
          free_r <= free_r + (NW+1)'(1);
          lvl_r <= lvl_r - LW'(1);
          state_r <= (lvl_r == LW'(1)) ? S_CP_LEAF_RD : S_CP_RD;
        end
        S_CP_LEAF_RD: state_r <= S_CP_LEAF_WT;
        S_CP_LEAF_WT: begin
          free_r <= free_r + (NW+1)'(1);
          if (!copy2_r) begin
            ny_r <= cur;
            copy2_r <= 1'b1;
            ce_r <= px_r;
            cp_r <= px_r;
            node_r <= root_r;
            lvl_r <= LW'(TREE_LEVELS);
            state_r <= S_CP_RD;
          end else begin
            nx_r <= cur;
            rk_nx_r <= rd_rank;
            key_nx_r <= rd_key;
            res_r.new_version <= root_r;
            state_r <= S_RANK_RD;
          end
        end
        S_RANK_RD: state_r <= S_RANK_WT;
        S_RANK_WT: state_r <= S_FIX;
        S_FIX: begin
          ov_r <= 1'b1;
          state_r <= S_IDLE;
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

  a_busy_stall: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r != S_IDLE) |-> in_stall) else $error("accepted while busy");
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_stall) |=> (out_valid && $stable(out_data)))
    else $error("result dropped");
  a_free_mono: assert property (@(posedge clk) disable iff (!rst_n)
    free_r >= $past(free_r) || $past(!rst_n)) else $error("free pointer moved back");
  a_pool_bound: assert property (@(posedge clk) disable iff (!rst_n)
    free_r <= POOL) else $error("pool overrun");
endmodule

[test/pufm_checker.sv]
`timescale 1ns / 1ps
module pufm_checker
  import pufm_pkg::*;
#(
  parameter int LEVELS = 10
) (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_valid,
  input  logic      in_stall,
  input  in_item_t  in_data,
  input  logic      out_valid,
  input  logic      out_stall,
  input  out_item_t out_data,
  output int        fails
);

  localparam int POOL   = 65536;
  localparam int LEAVES = 1 << LEVELS;
  localparam int ELEMS  = 1024;

  int unsigned lch[POOL];
  int unsigned rch[POOL];
  logic [9:0]  par[POOL];
  logic [3:0]  rnk[POOL];
  logic [31:0] key[POOL];
  int unsigned nfree;
  bit          joined;

  out_item_t   pending_results[$];

  function automatic void init_forest();
    for (int i = 0; i < POOL; i++) begin
      lch[i] = 0;
      rch[i] = 0;
      par[i] = '0;
      rnk[i] = '0;
      key[i] = '0;
    end
    for (int i = 1; i < LEAVES; i++) begin
      lch[i] = 2 * i;
      rch[i] = 2 * i + 1;
    end
    for (int i = LEAVES; i < 2 * LEAVES; i++) par[i] = 10'(i - LEAVES);
    nfree = 2 * LEAVES;
    joined = 0;
  endfunction

  function automatic int unsigned find_leaf(int unsigned v, int unsigned e);
    for (int i = LEVELS - 1; i >= 0; i--) begin
      v = e[i] ? rch[v % POOL] : lch[v % POOL];
    end
    return v % POOL;
  endfunction

  // follow parent links, bounded by the number of leaves
  function automatic int unsigned root_of(int unsigned v, int unsigned e);
    int unsigned leaf;
    int unsigned hops;
    leaf = find_leaf(v, e);
    hops = 0;
    while (par[leaf] != e && hops < LEAVES) begin
      e = par[leaf] & (LEAVES - 1);
      leaf = find_leaf(v, e);
      hops++;
    end
    return leaf;
  endfunction

  function automatic int unsigned clone_path(int unsigned v, int unsigned e, int unsigned p);
    int unsigned n;
    int unsigned c;
    for (int i = LEVELS - 1; i >= 0; i--) begin
      n = v % POOL;
      c = nfree % POOL;
      if (e[i]) begin
        lch[c] = lch[n];
        rch[c] = nfree + 1;
        v = rch[n];
      end else begin
        rch[c] = rch[n];
        lch[c] = nfree + 1;
        v = lch[n];
      end
      nfree++;
    end
    c = nfree % POOL;
    par[c] = 10'(p);
    rnk[c] = rnk[v % POOL];
    key[c] = key[v % POOL];
    nfree++;
    return nfree - 1 - LEVELS;
  endfunction

  function automatic out_item_t predict_result(in_item_t it);
    out_item_t   r;
    int unsigned ex, ey, rx, ry, t, px, py, nx, ny, v;
    r.new_version = it.version;
    r.min_key = '0;
    r.same_set = 1'b0;
    r.status = ST_OK;
    ex = 32'(it.first_element);
    ey = 32'(it.second_element);
    if (it.kind == KIND_LOAD) begin
      if (joined) r.status = ST_REJECTED;
      else if (ex < ELEMS) key[(LEAVES + (ex & (LEAVES - 1))) % POOL] = it.load_value;
    end else begin
      ex &= LEAVES - 1;
      ey &= LEAVES - 1;
      rx = root_of(32'(it.version), ex);
      if (it.kind == KIND_QMIN) begin
        r.min_key = key[rx];
      end else begin
        ry = root_of(32'(it.version), ey);
        if (it.kind == KIND_SAME) begin
          r.same_set = (par[rx] == par[ry]);
        end else begin
          joined = 1;
          if (par[rx] != par[ry]) begin
            if (nfree + 2 * (LEVELS + 1) > POOL) begin
              r.status = ST_EXHAUSTED;
            end else begin
              if (rnk[rx] < rnk[ry]) begin
                t = rx;
                rx = ry;
                ry = t;
              end
              px = 32'(par[rx]);
              py = 32'(par[ry]);
              v = clone_path(32'(it.version), py, px);
              ny = (nfree - 1) % POOL;
              v = clone_path(v, px, px);
              nx = (nfree - 1) % POOL;
              if (rnk[nx] == rnk[ny] && rnk[nx] < 4'd15) rnk[nx]++;
              if (key[ny] < key[nx]) key[nx] = key[ny];
              r.new_version = 16'(v);
            end
          end
        end
      end
    end
    return r;
  endfunction

  initial begin
    fails = 0;
    init_forest();
  end

  always @(posedge clk) begin
    out_item_t exp_r;
    if (rst_n && out_valid && !out_stall) begin
      if (pending_results.size() == 0) begin
        fails++;
        if (fails <= 10) $display("unexpected result beat: %p", out_data);
      end else begin
        exp_r = pending_results.pop_front();
        if (out_data.new_version !== exp_r.new_version ||
            out_data.min_key !== exp_r.min_key ||
            out_data.same_set !== exp_r.same_set || out_data.status !== exp_r.status) begin
          fails++;
          if (fails <= 10)
            $display("mismatch: exp ver=%0d min=%0h same=%0b st=%0d %s%0d %s%0h %s%0b %s%0d",
                     exp_r.new_version, exp_r.min_key, exp_r.same_set, exp_r.status,
                     "got ver=", out_data.new_version, "min=", out_data.min_key,
                     "same=", out_data.same_set, "st=", out_data.status);
        end
      end
    end
    if (rst_n && in_valid && !in_stall) pending_results.push_back(predict_result(in_data));
  end

  function automatic int leftover();
    return pending_results.size();
  endfunction

endmodule

[test/tb_top.sv]
`timescale 1ns / 1ps
module tb_top;
  import pufm_pkg::*;

  localparam int LIMIT = 4000000;

  logic      clk;
  logic      rst_n;
  logic      in_valid;
  logic      in_stall;
  in_item_t  in_data;
  logic      out_valid;
  logic      out_stall;
  out_item_t out_data;
  int        fails;

  int        sent;
  int        got;
  int        cycles;
  bit        no_gaps;
  int        versions[$];
  bit        seen_ver[int];
  int        latest_ver;

  persistent_union_find_min_unit dut (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_stall(in_stall), .in_data(in_data),
    .out_valid(out_valid), .out_stall(out_stall), .out_data(out_data)
  );

  pufm_checker chk (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_stall(in_stall), .in_data(in_data),
    .out_valid(out_valid), .out_stall(out_stall), .out_data(out_data),
    .fails(fails)
  );

  initial begin
    clk = 0;
    forever #10 clk = ~clk;
  end

  // track every version the block has handed back
  always @(posedge clk) begin
    cycles++;
    if (cycles > LIMIT) begin
      $display("CHECKS FAILED");
      $finish;
    end
    if (rst_n && out_valid && !out_stall) begin
      got++;
      if (!seen_ver.exists(out_data.new_version)) begin
        seen_ver[out_data.new_version] = 1;
        versions.push_back(out_data.new_version);
        latest_ver = out_data.new_version;
      end
    end
  end

  task automatic send_beat(logic [1:0] kind, int ver, int ea, int eb, logic [31:0] val);
    int r;
    int gap;
    @(negedge clk);
    r = $urandom_range(99);
    gap = 0;
    if (!no_gaps) begin
      if (r < 40) gap = $urandom_range(1, 3);
      else if (r < 48) gap = $urandom_range(10, 40);
      else if (r < 49) gap = $urandom_range(100, 200);
    end
    if (gap > 0) begin
      in_valid = 0;
      repeat (gap) @(negedge clk);
    end
    in_data.kind = kind;
    in_data.version = 16'(ver);
    in_data.first_element = 10'(ea);
    in_data.second_element = 10'(eb);
    in_data.load_value = val;
    in_valid = 1;
    do @(posedge clk); while (!(in_valid && !in_stall));
    sent++;
  endtask

  task automatic drain();
    @(negedge clk);
    in_valid = 0;
    while (sent != got) @(posedge clk);
  endtask

  function automatic int pick_elem();
    if ($urandom_range(9) < 7) return $urandom_range(0, 63);
    return $urandom_range(0, 1023);
  endfunction

  function automatic int pick_ver();
    if ($urandom_range(9) < 6) return latest_ver;
    return versions[$urandom_range(0, versions.size() - 1)];
  endfunction

  function automatic logic [31:0] rand_key();
    return $urandom();
  endfunction

  // receiver: one forced long hold, then random stalls
  initial begin
    out_stall = 1'b0;
    @(posedge rst_n);
    repeat (300) @(negedge clk);
    out_stall = 1'b1;
    repeat (500) @(negedge clk);
    forever begin
      int r;
      r = $urandom_range(99);
      if (r < 60) begin
        out_stall = 1'b0;
        repeat ($urandom_range(1, 8)) @(negedge clk);
      end else if (r < 95) begin
        out_stall = 1'b1;
        repeat ($urandom_range(1, 4)) @(negedge clk);
      end else begin
        out_stall = 1'b1;
        repeat ($urandom_range(20, 80)) @(negedge clk);
      end
    end
  end

  initial begin
    int k;
    int ver;
    in_valid = 0;
    in_data = '0;
    rst_n = 0;
    sent = 0;
    got = 0;
    cycles = 0;
    no_gaps = 0;
    versions.push_back(1);
    seen_ver[1] = 1;
    latest_ver = 1;
    repeat (9) @(posedge clk);
    @(negedge clk);
    rst_n = 1;

    // loads at the key and element extremes, queries on the initial version
    send_beat(KIND_LOAD, 1, 0, 0, 32'h0);
    send_beat(KIND_LOAD, 1, 1023, 0, 32'hFFFF_FFFF);
    send_beat(KIND_LOAD, 1, 1, 0, 32'd5);
    send_beat(KIND_LOAD, 1, 2, 0, 32'd7);
    send_beat(KIND_LOAD, 1, 512, 0, 32'd1);
    send_beat(KIND_QMIN, 1, 1023, 0, 32'h0);
    send_beat(KIND_QMIN, 1, 2, 1023, 32'h0);
    send_beat(KIND_SAME, 1, 0, 0, 32'h0);
    send_beat(KIND_SAME, 1, 0, 1023, 32'h0);
    for (int i = 0; i < 100; i++)
      send_beat(KIND_LOAD, 1, $urandom_range(3, 1022), 0, rand_key());
    drain();

    send_beat(KIND_JOIN, 1, 0, 1, 32'h0);
    drain();
    send_beat(KIND_JOIN, latest_ver, 1, 2, 32'h0);
    drain();
    send_beat(KIND_JOIN, latest_ver, 0, 2, 32'h0);
    send_beat(KIND_QMIN, latest_ver, 2, 0, 32'h0);
    send_beat(KIND_SAME, latest_ver, 0, 2, 32'h0);
    send_beat(KIND_SAME, 1, 0, 2, 32'h0);
    send_beat(KIND_LOAD, latest_ver, 5, 0, 32'h1234_5678);
    send_beat(KIND_JOIN, latest_ver, 1023, 512, 32'h0);
    drain();
    send_beat(KIND_QMIN, latest_ver, 1023, 0, 32'h0);
    send_beat(KIND_SAME, latest_ver, 512, 1023, 32'h0);

    for (int i = 0; i < 700; i++) begin
      no_gaps = (i >= 300 && i < 380);
      k = $urandom_range(99);
      ver = pick_ver();
      if (k < 35) send_beat(KIND_JOIN, ver, pick_elem(), pick_elem(), 32'h0);
      else if (k < 60) send_beat(KIND_QMIN, ver, pick_elem(), $urandom_range(0, 1023), rand_key());
      else if (k < 90) send_beat(KIND_SAME, ver, pick_elem(), pick_elem(), 32'h0);
      else send_beat(KIND_LOAD, ver, $urandom_range(0, 1023), 0, rand_key());
      if (i == 500) drain();
    end
    no_gaps = 0;

    for (int i = 0; i < 30; i++) begin
      ver = versions[$urandom_range(0, versions.size() - 1)];
      k = $urandom_range(2);
      if (k == 0) send_beat(KIND_JOIN, ver, pick_elem(), pick_elem(), 32'h0);
      else if (k == 1) send_beat(KIND_QMIN, ver, pick_elem(), 0, 32'h0);
      else send_beat(KIND_SAME, ver, pick_elem(), pick_elem(), 32'h0);
    end

    drain();
    repeat (600) @(posedge clk);
    if (fails == 0 && chk.leftover() == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule

[filelist.f]
sv/pufm_pkg.sv
sv/pufm_pool.sv
sv/persistent_union_find_min_unit.sv
test/pufm_checker.sv
test/tb_top.sv
